/* rtl/kcl_pkg.sv */
// kcl_pkg: shared types, codes, reset values and lookup tables of the keypad code lock
// used by kcl_cfg, kcl_core and keypad_code_lock_with_timeout; depends on nothing

package kcl_pkg;

    // buffer capacity default
    localparam int MAX_KEYS_DEF = 16;

    // beat kinds on the input side
    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // special keypad codes
    localparam logic [3:0] KEY_ENTER = 4'd7;
    localparam logic [3:0] KEY_CLEAR = 4'd15;

    // lcd actions
    localparam logic [2:0] LCD_NONE    = 3'd0;
    localparam logic [2:0] LCD_ECHO    = 3'd1;
    localparam logic [2:0] LCD_CORRECT = 3'd2;
    localparam logic [2:0] LCD_WRONG   = 3'd3;
    localparam logic [2:0] LCD_CLEARED = 3'd4;
    localparam logic [2:0] LCD_CLRLINE = 3'd5;

    // seven-segment actions
    localparam logic [1:0] DISP_NONE  = 2'd0;
    localparam logic [1:0] DISP_TENS  = 2'd1;
    localparam logic [1:0] DISP_ONES  = 2'd2;
    localparam logic [1:0] DISP_BLANK = 2'd3;

    // verdict codes
    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_CORRECT = 2'd1;
    localparam logic [1:0] VERDICT_WRONG   = 2'd2;

    // register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_CODE_KEYS   = 3'd0;
    localparam logic [2:0] REG_CODE_LENGTH = 3'd1;
    localparam logic [2:0] REG_TIMEOUT     = 3'd2;
    localparam logic [2:0] REG_TICKS_SEC   = 3'd3;
    localparam logic [2:0] REG_TONE_TICKS  = 3'd4;
    localparam logic [2:0] REG_WRONG_DIV   = 3'd5;

    // register reset values
    localparam logic [63:0] RST_CODE_KEYS   = 64'd13750317;
    localparam logic [4:0]  RST_CODE_LENGTH = 5'd6;
    localparam logic [3:0]  RST_TIMEOUT     = 4'd15;
    localparam logic [7:0]  RST_TICKS_SEC   = 8'd200;
    localparam logic [9:0]  RST_TONE_TICKS  = 10'd1000;
    localparam logic [2:0]  RST_WRONG_DIV   = 3'd4;

    // countdown start after reset
    localparam logic [3:0]  RST_SECONDS     = 4'd15;

    // segment bit 7 selects the second digit
    localparam logic [7:0] SEG_DIGIT2 = 8'b1000_0000;
    localparam logic [7:0] SEG_MASK   = 8'b0111_1111;

    typedef struct packed {
        logic [63:0] code_keys;
        logic [4:0]  code_length;
        logic [3:0]  timeout_seconds;
        logic [7:0]  ticks_per_second;
        logic [9:0]  tone_ticks;
        logic [2:0]  wrong_tone_divider;
    } t_cfg;

    typedef struct packed {
        logic [3:0] seconds_shown;
        logic       entry_active;
        logic [1:0] verdict;
        logic       timer_fast;
        logic       timer_running;
        logic       speaker_level;
        logic [7:0] display_byte;
        logic [1:0] display_action;
        logic [7:0] lcd_char;
        logic [2:0] lcd_action;
    } t_result;

    // keypad matrix code to ascii
    function automatic logic [7:0] key_ascii(input logic [3:0] code);
        logic [7:0] c;
        case (code)
            4'd0:    c = "1";
            4'd1:    c = "2";
            4'd2:    c = "3";
            4'd3:    c = "F";
            4'd4:    c = "4";
            4'd5:    c = "5";
            4'd6:    c = "6";
            4'd7:    c = "E";
            4'd8:    c = "7";
            4'd9:    c = "8";
            4'd10:   c = "9";
            4'd11:   c = "D";
            4'd12:   c = "A";
            4'd13:   c = "0";
            4'd14:   c = "B";
            default: c = "C";
        endcase
        return c;
    endfunction

    // decimal digit to active-low segment pattern
    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'h40;
            4'd1:    s = 8'h79;
            4'd2:    s = 8'h24;
            4'd3:    s = 8'h30;
            4'd4:    s = 8'h19;
            4'd5:    s = 8'h12;
            4'd6:    s = 8'h02;
            4'd7:    s = 8'h78;
            4'd8:    s = 8'h00;
            4'd9:    s = 8'h10;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

/* rtl/kcl_cfg.sv */
// kcl_cfg: apb register file holding the secret code and the timing settings
// depends on kcl_pkg for register indexes, reset values and the t_cfg struct

module kcl_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [5:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready,
    output kcl_pkg::t_cfg  o_cfg
);
    import kcl_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[5:3];
    assign o_cfg  = r_cfg;

    // register writes, upper bits dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_keys          <= RST_CODE_KEYS;
            r_cfg.code_length        <= RST_CODE_LENGTH;
            r_cfg.timeout_seconds    <= RST_TIMEOUT;
            r_cfg.ticks_per_second   <= RST_TICKS_SEC;
            r_cfg.tone_ticks         <= RST_TONE_TICKS;
            r_cfg.wrong_tone_divider <= RST_WRONG_DIV;
        end else if (w_wr) begin
            case (w_idx)
                REG_CODE_KEYS:   r_cfg.code_keys          <= pwdata;
                REG_CODE_LENGTH: r_cfg.code_length        <= pwdata[4:0];
                REG_TIMEOUT:     r_cfg.timeout_seconds    <= pwdata[3:0];
                REG_TICKS_SEC:   r_cfg.ticks_per_second   <= pwdata[7:0];
                REG_TONE_TICKS:  r_cfg.tone_ticks         <= pwdata[9:0];
                REG_WRONG_DIV:   r_cfg.wrong_tone_divider <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_CODE_KEYS:   prdata = r_cfg.code_keys;
            REG_CODE_LENGTH: prdata = {59'd0, r_cfg.code_length};
            REG_TIMEOUT:     prdata = {60'd0, r_cfg.timeout_seconds};
            REG_TICKS_SEC:   prdata = {56'd0, r_cfg.ticks_per_second};
            REG_TONE_TICKS:  prdata = {54'd0, r_cfg.tone_ticks};
            REG_WRONG_DIV:   prdata = {61'd0, r_cfg.wrong_tone_divider};
            default:         prdata = 64'd0;
        endcase
    end

endmodule

/* rtl/kcl_core.sv */
// kcl_core: lock state, key buffer, countdown and tone counters with their one-pass update
// depends on kcl_pkg for codes, tables and the t_cfg and t_result structs

module kcl_core #(
    parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_func,
    input  logic [3:0]        i_key,
    input  kcl_pkg::t_cfg     i_cfg,
    output kcl_pkg::t_result  o_res
);
    import kcl_pkg::*;

    localparam int CNTW = $clog2(MAX_KEYS + 1);
    localparam int IDXW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam logic [4:0]      MAX_KEYS_W = 5'(MAX_KEYS);
    localparam logic [CNTW-1:0] CNT_ONE    = CNTW'(1);

    // key buffer, entries below the configured code length are read for a match
    logic [3:0]      r_keys [0:MAX_KEYS-1];
    logic [CNTW-1:0] r_key_count, n_key_count;
    logic            r_entering, n_entering;
    logic [1:0]      r_result, n_result;
    logic [3:0]      r_seconds, n_seconds;
    logic [7:0]      r_sec_ticks, n_sec_ticks;
    logic [1:0]      r_div_cnt, n_div_cnt;
    logic [9:0]      r_tone_el, n_tone_el;
    logic            r_speaker, n_speaker;
    logic            r_digit, n_digit;
    logic            r_timer_en, n_timer_en;
    logic            r_fast, n_fast;

    logic            w_store;
    logic            w_bad;
    logic            w_tens;
    logic [3:0]      w_ones;
    logic [7:0]      w_sec_inc;
    logic [9:0]      w_tone_inc;
    logic [2:0]      w_div;
    logic [2:0]      w_div_inc;
    logic [2:0]      w_lcd_action;
    logic [7:0]      w_lcd_char;
    logic [1:0]      w_disp_action;
    logic [7:0]      w_disp_byte;

    // code check: length first, then each stored key against the secret
    always_comb begin
        w_bad = (i_cfg.code_length > MAX_KEYS_W) || (5'(r_key_count) != i_cfg.code_length);
        for (int i = 0; i < MAX_KEYS; i++) begin
            if ((5'(i) < i_cfg.code_length) && (r_keys[i] != i_cfg.code_keys[4*i +: 4])) begin
                w_bad = 1'b1;
            end
        end
    end

    // countdown digits and counter increments
    assign w_tens     = (r_seconds >= 4'd10);
    assign w_ones     = w_tens ? (r_seconds - 4'd10) : r_seconds;
    assign w_sec_inc  = r_sec_ticks + 8'd1;
    assign w_tone_inc = r_tone_el + 10'd1;
    assign w_div_inc  = {1'b0, r_div_cnt} + 3'd1;

    // wrong-tone divider clamped to 1..4
    always_comb begin
        if (i_cfg.wrong_tone_divider == 3'd0) begin
            w_div = 3'd1;
        end else if (i_cfg.wrong_tone_divider > 3'd4) begin
            w_div = 3'd4;
        end else begin
            w_div = i_cfg.wrong_tone_divider;
        end
    end

    // next state and result for one beat
    always_comb begin
        n_key_count   = r_key_count;
        n_entering    = r_entering;
        n_result      = r_result;
        n_seconds     = r_seconds;
        n_sec_ticks   = r_sec_ticks;
        n_div_cnt     = r_div_cnt;
        n_tone_el     = r_tone_el;
        n_speaker     = r_speaker;
        n_digit       = r_digit;
        n_timer_en    = r_timer_en;
        n_fast        = r_fast;
        w_store       = 1'b0;
        w_lcd_action  = LCD_NONE;
        w_lcd_char    = 8'd0;
        w_disp_action = DISP_NONE;
        w_disp_byte   = 8'd0;

        if (i_func == FUNC_KEY) begin
            if ((i_key == KEY_ENTER) || (i_key == KEY_CLEAR)) begin
                n_timer_en    = 1'b0;
                n_entering    = 1'b0;
                w_disp_action = DISP_BLANK;
                if (i_key == KEY_ENTER) begin
                    n_result     = w_bad ? VERDICT_WRONG : VERDICT_CORRECT;
                    w_lcd_action = w_bad ? LCD_WRONG : LCD_CORRECT;
                    n_fast       = 1'b1;
                    n_timer_en   = 1'b1;
                end else begin
                    n_result     = VERDICT_WRONG;
                    w_lcd_action = LCD_CLEARED;
                end
                n_key_count = '0;
            end else if (5'(r_key_count) < MAX_KEYS_W) begin
                // first key of an entry starts the countdown
                if (!r_entering) begin
                    n_timer_en = 1'b1;
                    n_fast     = 1'b0;
                    n_entering = 1'b1;
                    n_seconds  = i_cfg.timeout_seconds;
                    n_result   = VERDICT_NONE;
                end
                w_store      = 1'b1;
                n_key_count  = r_key_count + CNT_ONE;
                w_lcd_action = LCD_ECHO;
                w_lcd_char   = key_ascii(i_key);
            end
        end else if (r_timer_en) begin
            if ((r_result == VERDICT_NONE) && r_entering) begin
                // countdown tick: alternate digits, then count the second
                n_digit = ~r_digit;
                if (!n_digit) begin
                    if (w_tens) begin
                        w_disp_action = DISP_TENS;
                        w_disp_byte   = seg_digit(4'd1) & SEG_MASK;
                    end
                end else begin
                    w_disp_action = DISP_ONES;
                    w_disp_byte   = seg_digit(w_ones) | SEG_DIGIT2;
                end
                n_sec_ticks = w_sec_inc;
                if (r_seconds == 4'd0) begin
                    n_entering    = 1'b0;
                    n_result      = VERDICT_WRONG;
                    n_key_count   = '0;
                    w_lcd_action  = LCD_CLRLINE;
                    w_disp_action = DISP_BLANK;
                    w_disp_byte   = 8'd0;
                    n_timer_en    = 1'b0;
                end
                if (w_sec_inc == i_cfg.ticks_per_second) begin
                    if (r_seconds != 4'd0) begin
                        n_seconds = r_seconds - 4'd1;
                    end
                    n_sec_ticks = 8'd0;
                end
                n_fast = 1'b0;
            end else begin
                // verdict tone tick
                n_tone_el = w_tone_inc;
                if (r_result == VERDICT_CORRECT) begin
                    n_speaker = ~r_speaker;
                end else if (w_div_inc >= w_div) begin
                    n_div_cnt = 2'd0;
                    n_speaker = ~r_speaker;
                end else begin
                    n_div_cnt = w_div_inc[1:0];
                end
                if (w_tone_inc == i_cfg.tone_ticks) begin
                    n_timer_en   = 1'b0;
                    n_tone_el    = 10'd0;
                    n_div_cnt    = 2'd0;
                    w_lcd_action = LCD_CLRLINE;
                end
                n_fast = 1'b1;
            end
        end
    end

    // result of the beat, state fields as they stand after it
    always_comb begin
        o_res.lcd_action     = w_lcd_action;
        o_res.lcd_char       = w_lcd_char;
        o_res.display_action = w_disp_action;
        o_res.display_byte   = w_disp_byte;
        o_res.speaker_level  = n_speaker;
        o_res.timer_running  = n_timer_en;
        o_res.timer_fast     = n_fast;
        o_res.verdict        = n_result;
        o_res.entry_active   = n_entering;
        o_res.seconds_shown  = n_seconds;
    end

    // key buffer write
    always_ff @(posedge i_clk) begin
        if (i_step && w_store) begin
            r_keys[r_key_count[IDXW-1:0]] <= i_key;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_entering  <= 1'b0;
            r_result    <= VERDICT_WRONG;
            r_seconds   <= RST_SECONDS;
            r_sec_ticks <= 8'd0;
            r_div_cnt   <= 2'd0;
            r_tone_el   <= 10'd0;
            r_speaker   <= 1'b0;
            r_digit     <= 1'b0;
            r_timer_en  <= 1'b0;
            r_fast      <= 1'b0;
        end else if (i_step) begin
            r_key_count <= n_key_count;
            r_entering  <= n_entering;
            r_result    <= n_result;
            r_seconds   <= n_seconds;
            r_sec_ticks <= n_sec_ticks;
            r_div_cnt   <= n_div_cnt;
            r_tone_el   <= n_tone_el;
            r_speaker   <= n_speaker;
            r_digit     <= n_digit;
            r_timer_en  <= n_timer_en;
            r_fast      <= n_fast;
        end
    end

endmodule

/* rtl/keypad_code_lock_with_timeout.sv */
// keypad_code_lock_with_timeout: top level with input register, output register and apb port
// depends on kcl_pkg, kcl_cfg and kcl_core
//
// Keypad code lock. Each input beat is a key press (tuser 0, key code in tdata[3:0]) or one
// timer tick (tuser 1) and gives exactly one output beat carrying the display and tone
// actions and the lock state after the event. A beat is taken every cycle while the input
// side is ready. Its result is offered once it reaches the output register and is taken
// when the output side is ready. The beat is held in the input register, then goes
// through the single-pass update into the output register. The output register parts the
// two sides, so one waiting result does not stop the next beat from entering; only a second
// held beat behind a stalled result stops the input. Registers sit at byte addresses 0, 8,
// 16, 24, 32 and 40 (code keys, code length, timeout, ticks per second, tone ticks,
// wrong-tone divider); the user must write them only while no beat is in flight, and the
// block itself does not enforce this. No clearing pass is needed after reset.

module keypad_code_lock_with_timeout #(
    parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [3:0] key_code, [7:4] zero
    input  logic [0:0]  s_axis_tuser,   // [0] func
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [2:0] lcd_action, [10:3] lcd_char,
                                        // [12:11] display_action, [20:13] display_byte,
                                        // [21] speaker_level, [22] timer_running,
                                        // [23] timer_fast, [25:24] verdict,
                                        // [26] entry_active, [30:27] seconds_shown, [31] zero
);
    import kcl_pkg::*;

    t_cfg       w_cfg;
    t_result    w_res;
    t_result    r_out;
    logic       r_out_valid;
    logic       r_in_valid;
    logic       r_in_func;
    logic [3:0] r_in_key;
    logic       w_adv;

    // register file
    kcl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // lock state and update
    kcl_core #(
        .MAX_KEYS (MAX_KEYS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_func  (r_in_func),
        .i_key   (r_in_key),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // a held beat moves on when the output register is free or being emptied
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= s_axis_tuser[0];
            r_in_key  <= s_axis_tdata[3:0];
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.seconds_shown, r_out.entry_active, r_out.verdict,
                            r_out.timer_fast, r_out.timer_running, r_out.speaker_level,
                            r_out.display_byte, r_out.display_action, r_out.lcd_char,
                            r_out.lcd_action};

    // a new result only ever follows a held input beat
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without an input beat");

    // a held beat with a stalled result blocks the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages are full");

    // an echoed key always belongs to a live entry
    a_echo_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.lcd_action == LCD_ECHO)
        |-> r_out.entry_active && (r_out.verdict == VERDICT_NONE))
        else $error("key echoed outside an entry");

    // a verdict starts the tone at the fast rate
    a_verdict_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out.lcd_action == LCD_CORRECT) || (r_out.lcd_action == LCD_WRONG))
        |-> r_out.timer_running && r_out.timer_fast && !r_out.entry_active)
        else $error("verdict without tone timer");

    // a character only travels with an echo
    a_char_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.lcd_char != 8'd0) |-> (r_out.lcd_action == LCD_ECHO))
        else $error("lcd character without echo action");

endmodule
